// ===== design/rsp_pkg.sv =====
//------------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants for the ray versus square plane patch block.
//------------------------------------------------------------------------------
package rsp_pkg;

	localparam int TW = 31;
	localparam int QW = 48;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		REASON_HIT      = 2'd0,
		REASON_PARALLEL = 2'd1,
		REASON_BEHIND   = 2'd2,
		REASON_OUTSIDE  = 2'd3
	} reason_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_NORMAL   = 3'd3,
		REG_AXIS     = 3'd4,
		REG_SIDE     = 3'd5,
		REG_LIMIT    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
		logic               reject;
		reason_t            reason;
		logic [48:0]        an;
		logic [47:0]        ad;
	} front_req_t;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [47:0]        normal;
		logic [47:0]        axis;
		logic [30:0]        side;
		logic [15:0]        limit;
	} cfg_t;

endpackage

// ===== design/rsp_front.sv =====
//------------------------------------------------------------------------------
// rsp_front
// Accepts rays, forms the two dot products and classifies parallel and
// behind rays in a two stage pipeline.
//------------------------------------------------------------------------------
module rsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  rsp_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  ox,
	input  logic signed [31:0]  oy,
	input  logic signed [31:0]  oz,
	input  logic signed [31:0]  dx,
	input  logic signed [31:0]  dy,
	input  logic signed [31:0]  dz,
	output logic                out_valid,
	input  logic                out_ready,
	output rsp_pkg::front_req_t out_req
);
	import rsp_pkg::*;

	logic               v_s1, v_s2;
	logic signed [31:0] ox_s1, oy_s1, oz_s1, dx_s1, dy_s1, dz_s1;
	logic signed [48:0] dnx_s1, dny_s1, dnz_s1, nmx_s1, nmy_s1, nmz_s1;
	logic signed [50:0] den, num;
	logic               adv1, adv2;
	logic [50:0]        aden, anum;
	logic               rej;
	reason_t            rsn;
	front_req_t         req_s2;
	logic signed [15:0] nx, ny, nz;

	assign nx = cfg.normal[15:0];
	assign ny = cfg.normal[31:16];
	assign nz = cfg.normal[47:32];

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			ox_s1 <= ox; oy_s1 <= oy; oz_s1 <= oz;
			dx_s1 <= dx; dy_s1 <= dy; dz_s1 <= dz;
			dnx_s1 <= 49'(dx * nx);
			dny_s1 <= 49'(dy * ny);
			dnz_s1 <= 49'(dz * nz);
			nmx_s1 <= 49'((34'(cfg.px) - 34'(ox)) * nx);
			nmy_s1 <= 49'((34'(cfg.py) - 34'(oy)) * ny);
			nmz_s1 <= 49'((34'(cfg.pz) - 34'(oz)) * nz);
		end
	end

	always_comb begin
		den  = 51'(dnx_s1) + 51'(dny_s1) + 51'(dnz_s1);
		num  = 51'(nmx_s1) + 51'(nmy_s1) + 51'(nmz_s1);
		aden = den[50] ? 51'(-den) : den;
		anum = num[50] ? 51'(-num) : num;
		rej  = 1'b0;
		rsn  = REASON_HIT;
		if (den == '0 || aden < {21'd0, cfg.limit, 14'd0}) begin
			rej = 1'b1;
			rsn = REASON_PARALLEL;
		end else if (num != '0 && (num[50] != den[50])) begin
			rej = 1'b1;
			rsn = REASON_BEHIND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			req_s2.ox <= ox_s1; req_s2.oy <= oy_s1; req_s2.oz <= oz_s1;
			req_s2.dx <= dx_s1; req_s2.dy <= dy_s1; req_s2.dz <= dz_s1;
			req_s2.reject <= rej;
			req_s2.reason <= rsn;
			req_s2.an <= anum[48:0];
			req_s2.ad <= aden[47:0];
		end
	end

	assign out_valid = v_s2;
	assign out_req   = req_s2;

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> v_s2 && $stable(req_s2))
		else $error("front result lost under stall");
	ap_par: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && req_s2.reason == REASON_PARALLEL |-> req_s2.reject)
		else $error("parallel request not rejected");
	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("front stalls while empty");

endmodule

// ===== design/rsp_queue.sv =====
//------------------------------------------------------------------------------
// rsp_queue
// Small first-in first-out queue that decouples the front from the back.
//------------------------------------------------------------------------------
module rsp_queue #(
	parameter int DEPTH = rsp_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rsp_pkg::front_req_t in_req,
	output logic                out_valid,
	input  logic                out_ready,
	output rsp_pkg::front_req_t out_req
);
	import rsp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	front_req_t      mem_q [DEPTH];
	logic [AW-1:0]   wp_q, rp_q;
	logic [AW:0]     cnt_q;
	logic            push, pop;

	assign in_ready  = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;
	assign out_req = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : AW'(wp_q + 1'b1);
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : AW'(rp_q + 1'b1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	ap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH))
		else $error("queue count out of range");
	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count not advanced");
	ap_drop: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count not reduced");

endmodule

// ===== design/rsp_back.sv =====
//------------------------------------------------------------------------------
// rsp_back
// Carries out a classified ray: pipelined restoring divide for t, hit point,
// projections onto the patch axes and the square test.
//------------------------------------------------------------------------------
module rsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rsp_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  rsp_pkg::front_req_t in_req,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                hit,
	output logic [1:0]          miss_reason,
	output logic [30:0]         hit_distance,
	output logic signed [31:0]  hit_x,
	output logic signed [31:0]  hit_y,
	output logic signed [31:0]  hit_z
);
	import rsp_pkg::*;

	// Quotient has 15 integer bits plus 16 fraction bits, one bit per stage;
	// the seed stage detects quotients of 32768 and above.
	localparam int NB = 31;
	localparam int NS = NB + 5;

	typedef struct packed {
		logic signed [31:0] ox, oy, oz, dx, dy, dz;
		logic               reject;
		reason_t            reason;
		logic               sat;
	} ctx_t;

	logic          adv;
	logic [NS-1:0] v_q;
	ctx_t          ctx_q [NS];

	logic [QW:0]   rem_q [NB+1];
	logic [QW-1:0] ad_q  [NB+1];
	logic [TW-1:0] qt_q  [NB+1];
	logic [NB-1:0] lo_q  [NB+1];

	logic [30:0]          t_s;
	logic signed [63:0]   mx_s, my_s, mz_s;
	logic signed [31:0]   hx_s, hy_s, hz_s;
	logic signed [32:0]   qx_s, qy_s, qz_s;
	logic signed [49:0]   p1x_s, p1y_s, p1z_s, p2x_s, p2y_s, p2z_s;
	logic signed [52:0]   pr1_s, pr2_s;
	logic signed [17:0]   cx_q, cy_q, cz_q;
	logic                 ohit_q;
	reason_t              orsn_q;
	logic [30:0]          ot_q;
	logic signed [31:0]   ox_q, oy_q, oz_q;

	logic signed [15:0] nx, ny, nz, ax, ay, az;
	logic signed [32:0] cxw, cyw, czw;

	assign nx = cfg.normal[15:0];
	assign ny = cfg.normal[31:16];
	assign nz = cfg.normal[47:32];
	assign ax = cfg.axis[15:0];
	assign ay = cfg.axis[31:16];
	assign az = cfg.axis[47:32];

	assign cxw = 33'(ny * az) - 33'(nz * ay) + 33'sd8192;
	assign cyw = 33'(nz * ax) - 33'(nx * az) + 33'sd8192;
	assign czw = 33'(nx * ay) - 33'(ny * ax) + 33'sd8192;

	// Configuration must be held static while rays are in flight; the block does not enforce this.
	always_ff @(posedge clk) begin
		cx_q <= 18'(cxw >>> 14);
		cy_q <= 18'(cyw >>> 14);
		cz_q <= 18'(czw >>> 14);
	end

	assign adv = !v_q[NS-1] || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_q[0].ox <= in_req.ox; ctx_q[0].oy <= in_req.oy; ctx_q[0].oz <= in_req.oz;
			ctx_q[0].dx <= in_req.dx; ctx_q[0].dy <= in_req.dy; ctx_q[0].dz <= in_req.dz;
			ctx_q[0].reject <= in_req.reject;
			ctx_q[0].reason <= in_req.reason;
			ctx_q[0].sat <= {15'd0, in_req.an} >= {1'b0, in_req.ad, 15'd0};
			rem_q[0]  <= in_req.an >> 15;
			ad_q[0]   <= in_req.ad;
			qt_q[0]   <= '0;
			lo_q[0]   <= {in_req.an[14:0], 16'd0};
			for (int k = 1; k < NS; k++) begin
				ctx_q[k] <= ctx_q[k-1];
			end
		end
	end

	// Restoring division of the numerator scaled by 2^16, one quotient bit per
	// stage; the numerator bits above the lowest 15 form the seed remainder.
	for (genvar g = 0; g < NB; g++) begin : g_div
		logic [QW+1:0] tr;
		logic [QW:0]   sh;
		always_comb begin
			sh = {rem_q[g][QW-1:0], lo_q[g][NB-1]};
			tr = {1'b0, sh} - {2'b0, ad_q[g]};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!tr[QW+1]) begin
					rem_q[g+1] <= tr[QW:0];
					qt_q[g+1]  <= {qt_q[g][TW-2:0], 1'b1};
				end else begin
					rem_q[g+1] <= sh;
					qt_q[g+1]  <= {qt_q[g][TW-2:0], 1'b0};
				end
				ad_q[g+1] <= ad_q[g];
				lo_q[g+1] <= {lo_q[g][NB-2:0], 1'b0};
			end
		end
	end

	assign t_s = ctx_q[NB].sat ? 31'h7FFFFFFF : qt_q[NB];

	logic [30:0]        t_a;
	logic signed [31:0] hx_a, hy_a, hz_a;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_a  <= t_s;
			mx_s <= ctx_q[NB].dx * $signed({1'b0, t_s});
			my_s <= ctx_q[NB].dy * $signed({1'b0, t_s});
			mz_s <= ctx_q[NB].dz * $signed({1'b0, t_s});
		end
	end

	function automatic logic signed [31:0] sat_add(logic signed [31:0] o,
			logic signed [63:0] m);
		logic signed [49:0] s;
		s = 50'(o) + 50'(m >>> 16);
		if (s > 50'sd2147483647) return 32'sh7FFFFFFF;
		if (s < -50'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction

	logic [30:0] t_b;
	always_ff @(posedge clk) begin
		if (adv) begin
			t_b  <= t_a;
			hx_a <= sat_add(ctx_q[NB+1].ox, mx_s);
			hy_a <= sat_add(ctx_q[NB+1].oy, my_s);
			hz_a <= sat_add(ctx_q[NB+1].oz, mz_s);
		end
	end

	assign qx_s = 33'(hx_a) - 33'(cfg.px);
	assign qy_s = 33'(hy_a) - 33'(cfg.py);
	assign qz_s = 33'(hz_a) - 33'(cfg.pz);

	logic [30:0] t_c;
	always_ff @(posedge clk) begin
		if (adv) begin
			t_c <= t_b;
			hx_s <= hx_a; hy_s <= hy_a; hz_s <= hz_a;
			p1x_s <= 50'(qx_s * ax); p1y_s <= 50'(qy_s * ay); p1z_s <= 50'(qz_s * az);
			p2x_s <= 50'(qx_s * cx_q); p2y_s <= 50'(qy_s * cy_q); p2z_s <= 50'(qz_s * cz_q);
		end
	end

	logic [52:0] m1, m2;
	logic [53:0] lim;
	assign pr1_s = 53'(p1x_s) + 53'(p1y_s) + 53'(p1z_s);
	assign pr2_s = 53'(p2x_s) + 53'(p2y_s) + 53'(p2z_s);
	assign m1 = pr1_s[52] ? 53'(-pr1_s) : pr1_s;
	assign m2 = pr2_s[52] ? 53'(-pr2_s) : pr2_s;
	assign lim = {9'd0, cfg.side, 14'd0};

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ctx_q[NB+3].reject) begin
				ohit_q <= 1'b0;
				orsn_q <= ctx_q[NB+3].reason;
				ot_q <= '0; ox_q <= '0; oy_q <= '0; oz_q <= '0;
			end else begin
				ot_q <= t_c; ox_q <= hx_s; oy_q <= hy_s; oz_q <= hz_s;
				if ({m1, 1'b0} > lim || {m2, 1'b0} > lim) begin
					ohit_q <= 1'b0;
					orsn_q <= REASON_OUTSIDE;
				end else begin
					ohit_q <= 1'b1;
					orsn_q <= REASON_HIT;
				end
			end
		end
	end

	assign out_valid    = v_q[NS-1];
	assign hit          = ohit_q;
	assign miss_reason  = orsn_q;
	assign hit_distance = ot_q;
	assign hit_x = ox_q;
	assign hit_y = oy_q;
	assign hit_z = oz_q;

	ap_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit == (miss_reason == REASON_HIT)))
		else $error("hit flag disagrees with reason");
	ap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (miss_reason == REASON_PARALLEL || miss_reason == REASON_BEHIND)
		|-> hit_distance == '0)
		else $error("rejected ray carries a distance");
	ap_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_distance))
		else $error("result changed under stall");

endmodule

// ===== design/ray_square_plane_intersect.sv =====
//------------------------------------------------------------------------------
// ray_square_plane_intersect
// Ray versus square plane patch test with an APB-style configuration port.
//------------------------------------------------------------------------------
// The path holds 39 register stages: 2 front, 1 queue, 36 back, 31 of them the
// divider. Throughput: one request per cycle while out_ready holds; a stalled
// result holds the back part and the four-entry queue absorbs the front. Reset
// clears all valid state and loads the register reset values; no clearing pass
// is needed.
module ray_square_plane_intersect (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] ray_origin_x,
	input  logic signed [31:0] ray_origin_y,
	input  logic signed [31:0] ray_origin_z,
	input  logic signed [31:0] ray_dir_x,
	input  logic signed [31:0] ray_dir_y,
	input  logic signed [31:0] ray_dir_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [1:0]         miss_reason,
	output logic [30:0]        hit_distance,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z
);
	import rsp_pkg::*;

	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] idx;
	logic       f_v, f_r, q_v, q_r;
	front_req_t f_req, q_req;

	assign pready = 1'b1;
	assign wr  = psel && penable && pwrite;
	assign idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.px <= '0; cfg_q.py <= '0; cfg_q.pz <= '0;
			cfg_q.normal <= 48'd16384;
			cfg_q.axis <= 48'd70368744177664;
			cfg_q.side <= 31'd65536;
			cfg_q.limit <= 16'd1;
		end else if (wr) begin
			unique case (idx)
				REG_ORIGIN_X: cfg_q.px <= pwdata[31:0];
				REG_ORIGIN_Y: cfg_q.py <= pwdata[31:0];
				REG_ORIGIN_Z: cfg_q.pz <= pwdata[31:0];
				REG_NORMAL:   cfg_q.normal <= pwdata[47:0];
				REG_AXIS:     cfg_q.axis <= pwdata[47:0];
				REG_SIDE:     cfg_q.side <= pwdata[30:0];
				REG_LIMIT:    cfg_q.limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ORIGIN_X: prdata = 64'(unsigned'(cfg_q.px));
			REG_ORIGIN_Y: prdata = 64'(unsigned'(cfg_q.py));
			REG_ORIGIN_Z: prdata = 64'(unsigned'(cfg_q.pz));
			REG_NORMAL:   prdata = 64'(cfg_q.normal);
			REG_AXIS:     prdata = 64'(cfg_q.axis);
			REG_SIDE:     prdata = 64'(cfg_q.side);
			REG_LIMIT:    prdata = 64'(cfg_q.limit);
			default:      prdata = '0;
		endcase
	end

	rsp_front u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid, .in_ready,
		.ox(ray_origin_x), .oy(ray_origin_y), .oz(ray_origin_z),
		.dx(ray_dir_x), .dy(ray_dir_y), .dz(ray_dir_z),
		.out_valid(f_v), .out_ready(f_r), .out_req(f_req)
	);

	rsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.in_valid(f_v), .in_ready(f_r), .in_req(f_req),
		.out_valid(q_v), .out_ready(q_r), .out_req(q_req)
	);

	rsp_back u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid(q_v), .in_ready(q_r), .in_req(q_req),
		.out_valid, .out_ready,
		.hit, .miss_reason, .hit_distance, .hit_x, .hit_y, .hit_z
	);

endmodule
